// File: design/ycc_pkg.sv
// Shared constants, command codes and controller/datapath types for the colour-class table.
package ycc_pkg;

  // Downsampling and table geometry.
  localparam int LUMA_BITS   = 4;
  localparam int CHROMA_BITS = 6;
  localparam int NUM_COLORS  = 8;

  // Field widths of the input and result items.
  localparam int CMD_W  = 2;
  localparam int PIX_W  = 8;
  localparam int CIDX_W = 3;
  localparam int YR_W   = 4;
  localparam int CR_W   = 6;
  localparam int FLAG_W = 8;

  localparam int ADDR_W      = LUMA_BITS + 2 * CHROMA_BITS;
  localparam int TABLE_DEPTH = 2 ** ADDR_W;

  // Widths wide enough to hold a downsampled coordinate plus its box range.
  localparam int YS_W = ((LUMA_BITS > YR_W) ? LUMA_BITS : YR_W) + 1;
  localparam int CS_W = ((CHROMA_BITS > CR_W) ? CHROMA_BITS : CR_W) + 1;

  localparam logic [LUMA_BITS-1:0]   Y_MAX = '1;
  localparam logic [CHROMA_BITS-1:0] C_MAX = '1;

  typedef logic [CMD_W-1:0] cmd_code_t;

  localparam cmd_code_t CMD_CLASSIFY = 2'd0;
  localparam cmd_code_t CMD_ADD      = 2'd1;
  localparam cmd_code_t CMD_REMOVE   = 2'd2;
  localparam cmd_code_t CMD_CLEAR    = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic look;
    logic setup;
    logic step;
    logic load_flags;
    logic load_zero;
  } dp_ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_classify;
    logic color_ok;
    logic walk_last;
  } dp_stat_t;

endpackage

// File: design/ycc_if.sv
// Valid/ready channel interfaces for command items and result items.
interface ycc_in_if;
  import ycc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CMD_W-1:0]      cmd;
  logic [PIX_W-1:0]      luma;
  logic [PIX_W-1:0]      red_diff;
  logic [PIX_W-1:0]      blue_diff;
  logic [CIDX_W-1:0]     color_index;
  logic [YR_W-1:0]       luma_range;
  logic [CR_W-1:0]       chroma_range;

  modport source (
    output valid, cmd, luma, red_diff, blue_diff, color_index, luma_range, chroma_range,
    input  ready
  );
  modport sink (
    input  valid, cmd, luma, red_diff, blue_diff, color_index, luma_range, chroma_range,
    output ready
  );
endinterface

interface ycc_out_if;
  import ycc_pkg::*;

  logic              valid;
  logic              ready;
  logic [FLAG_W-1:0] color_flags;
  logic [FLAG_W-1:0] color_mask;

  modport source (
    output valid, color_flags, color_mask,
    input  ready
  );
  modport sink (
    input  valid, color_flags, color_mask,
    output ready
  );
endinterface

// File: design/ycrcb_color_class_lut.sv
// Top level of the YCrCb colour-class lookup table.
//
//   Channel   Direction  Handshake      Carries
//   in_chan   sink       valid/ready    one command item: cmd, pixel, colour, box ranges
//   out_chan  source     valid/ready    one result item per command: color_flags, color_mask
//
// After reset the table is swept to zero, one entry a cycle, over all 65536 entries; no item is
// accepted during that pass. A classify item is accepted, reads the table, then loads the result.
// An add or remove item is accepted, sets up its clipped box and walks every entry in it, and a
// clear item walks the whole table; the walker issues one read-modify-write per cycle
// through the single memory read and write port. A new item is accepted only once the previous
// result has left the output register, or in the cycle in which it leaves, so a stalled result
// holds the input for as long as it waits.
module ycrcb_color_class_lut
  import ycc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  ycc_in_if.sink   in_chan,
  ycc_out_if.source out_chan
);

  dp_ctrl_t ctrl;
  dp_stat_t stat;

  // The controller steps through lookups and box walks and owns both handshakes.
  ycc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  // The datapath holds the table, the box walker and the result register.
  ycc_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctrl            (ctrl),
    .stat            (stat),
    .in_cmd          (in_chan.cmd),
    .in_luma         (in_chan.luma),
    .in_red_diff     (in_chan.red_diff),
    .in_blue_diff    (in_chan.blue_diff),
    .in_color_index  (in_chan.color_index),
    .in_luma_range   (in_chan.luma_range),
    .in_chroma_range (in_chan.chroma_range),
    .out_color_flags (out_chan.color_flags),
    .out_color_mask  (out_chan.color_mask)
  );

endmodule

// File: design/ycc_dpath.sv
// Datapath: command capture, box bounds, table walker, lookup memory and result register.
module ycc_dpath
  import ycc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  dp_ctrl_t          ctrl,
  output dp_stat_t          stat,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [PIX_W-1:0]  in_luma,
  input  logic [PIX_W-1:0]  in_red_diff,
  input  logic [PIX_W-1:0]  in_blue_diff,
  input  logic [CIDX_W-1:0] in_color_index,
  input  logic [YR_W-1:0]   in_luma_range,
  input  logic [CR_W-1:0]   in_chroma_range,
  output logic [FLAG_W-1:0] out_color_flags,
  output logic [FLAG_W-1:0] out_color_mask
);

  // Captured command.
  cmd_code_t              cmd_r;
  logic [LUMA_BITS-1:0]   ys_r;
  logic [CHROMA_BITS-1:0] crs_r;
  logic [CHROMA_BITS-1:0] cbs_r;
  logic [YR_W-1:0]        yr_r;
  logic [CR_W-1:0]        crr_r;
  logic [FLAG_W-1:0]      flag_r;
  logic                   color_ok_r;
  logic                   set_r;
  logic                   zero_r;

  // Box bounds and walker position.
  logic [LUMA_BITS-1:0]   y_hi_r, y_r;
  logic [CHROMA_BITS-1:0] r_lo_r, r_hi_r, r_r;
  logic [CHROMA_BITS-1:0] b_lo_r, b_hi_r, b_r;

  // Read-modify-write pipeline.
  logic                   wr_pend_r;
  logic [ADDR_W-1:0]      wr_addr_r;
  logic [FLAG_W-1:0]      rd_data_r;
  logic [FLAG_W-1:0]      mem [TABLE_DEPTH];

  logic [FLAG_W-1:0]      flags_r;
  logic [FLAG_W-1:0]      mask_r;

  logic [YS_W-1:0]        ys_ext, yr_ext, y_sum;
  logic [CS_W-1:0]        crs_ext, cbs_ext, crr_ext, r_sum, b_sum;
  logic [LUMA_BITS-1:0]   y_lo, y_hi;
  logic [CHROMA_BITS-1:0] r_lo, r_hi, b_lo, b_hi;
  logic                   y_end, r_end, b_end;
  logic [ADDR_W-1:0]      walk_addr, rd_addr;
  logic                   rd_en;
  logic [FLAG_W-1:0]      wr_data;

  // Box bounds, clipped to the table along each axis.
  always_comb begin
    ys_ext  = YS_W'(ys_r);
    yr_ext  = YS_W'(yr_r);
    crs_ext = CS_W'(crs_r);
    cbs_ext = CS_W'(cbs_r);
    crr_ext = CS_W'(crr_r);
    y_sum   = ys_ext + yr_ext;
    r_sum   = crs_ext + crr_ext;
    b_sum   = cbs_ext + crr_ext;
    y_lo = (ys_ext >= yr_ext) ? LUMA_BITS'(ys_ext - yr_ext) : '0;
    r_lo = (crs_ext >= crr_ext) ? CHROMA_BITS'(crs_ext - crr_ext) : '0;
    b_lo = (cbs_ext >= crr_ext) ? CHROMA_BITS'(cbs_ext - crr_ext) : '0;
    y_hi = (y_sum > YS_W'(Y_MAX)) ? Y_MAX : LUMA_BITS'(y_sum);
    r_hi = (r_sum > CS_W'(C_MAX)) ? C_MAX : CHROMA_BITS'(r_sum);
    b_hi = (b_sum > CS_W'(C_MAX)) ? C_MAX : CHROMA_BITS'(b_sum);
    if (cmd_r == CMD_CLEAR) begin
      y_lo = '0;
      r_lo = '0;
      b_lo = '0;
      y_hi = Y_MAX;
      r_hi = C_MAX;
      b_hi = C_MAX;
    end
  end

  assign y_end     = (y_r == y_hi_r);
  assign r_end     = (r_r == r_hi_r);
  assign b_end     = (b_r == b_hi_r);
  assign walk_addr = {y_r, r_r, b_r};
  assign rd_en     = ctrl.step | ctrl.look;
  assign rd_addr   = ctrl.look ? {ys_r, crs_r, cbs_r} : walk_addr;

  always_comb begin
    if (zero_r) begin
      wr_data = '0;
    end else if (set_r) begin
      wr_data = rd_data_r | flag_r;
    end else begin
      wr_data = rd_data_r & ~flag_r;
    end
  end

  assign stat.in_classify = (in_cmd == CMD_CLASSIFY);
  assign stat.color_ok    = color_ok_r;
  assign stat.walk_last   = y_end & r_end & b_end;

  // Command capture; the payload needs no reset.
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cmd_r      <= in_cmd;
      ys_r       <= in_luma[PIX_W-1 -: LUMA_BITS];
      crs_r      <= in_red_diff[PIX_W-1 -: CHROMA_BITS];
      cbs_r      <= in_blue_diff[PIX_W-1 -: CHROMA_BITS];
      yr_r       <= in_luma_range;
      crr_r      <= in_chroma_range;
      flag_r     <= FLAG_W'(1) << in_color_index;
      color_ok_r <= ((CIDX_W + 1)'(in_color_index) < (CIDX_W + 1)'(NUM_COLORS));
    end
  end

  // Walker and write mode. Reset leaves them set up for the clearing pass over the table.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_r     <= 1'b0;
      zero_r    <= 1'b1;
      r_lo_r    <= '0;
      b_lo_r    <= '0;
      y_hi_r    <= Y_MAX;
      r_hi_r    <= C_MAX;
      b_hi_r    <= C_MAX;
      y_r       <= '0;
      r_r       <= '0;
      b_r       <= '0;
      wr_pend_r <= 1'b0;
    end else begin
      wr_pend_r <= ctrl.step;
      if (ctrl.capture) begin
        set_r  <= (in_cmd == CMD_ADD);
        zero_r <= 1'b0;
      end
      if (ctrl.setup) begin
        r_lo_r <= r_lo;
        b_lo_r <= b_lo;
        y_hi_r <= y_hi;
        r_hi_r <= r_hi;
        b_hi_r <= b_hi;
        y_r    <= y_lo;
        r_r    <= r_lo;
        b_r    <= b_lo;
      end else if (ctrl.step) begin
        if (!b_end) begin
          b_r <= b_r + 1'b1;
        end else begin
          b_r <= b_lo_r;
          if (!r_end) begin
            r_r <= r_r + 1'b1;
          end else begin
            r_r <= r_lo_r;
            y_r <= y_r + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step) begin
      wr_addr_r <= walk_addr;
    end
  end

  // Lookup table: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_pend_r) begin
      mem[wr_addr_r] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (ctrl.load_flags) begin
      flags_r <= rd_data_r;
      mask_r  <= (color_ok_r && ((rd_data_r & flag_r) != '0)) ? '1 : '0;
    end else if (ctrl.load_zero) begin
      flags_r <= '0;
      mask_r  <= '0;
    end
  end

  assign out_color_flags = flags_r;
  assign out_color_mask  = mask_r;

endmodule

// File: design/ycc_ctrl.sv
// Controller: sequences the clearing pass, lookups and box walks, and owns the handshakes.
module ycc_ctrl
  import ycc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_ctrl_t ctrl
);

  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_LOOK  = 3'd2;
  localparam logic [2:0] ST_RESP  = 3'd3;
  localparam logic [2:0] ST_SETUP = 3'd4;
  localparam logic [2:0] ST_WALK  = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;

  // The result register is free, or is being emptied in this cycle.
  assign in_ready  = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt       = state_r;
    ctrl            = '0;
    out_valid_nxt   = out_valid_r && !out_ready;
    case (state_r)
      ST_INIT: begin
        ctrl.step = 1'b1;
        if (stat.walk_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          ctrl.capture = 1'b1;
          state_nxt    = stat.in_classify ? ST_LOOK : ST_SETUP;
        end
      end
      ST_LOOK: begin
        ctrl.look = 1'b1;
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        ctrl.load_flags = 1'b1;
        out_valid_nxt   = 1'b1;
        state_nxt       = ST_IDLE;
      end
      ST_SETUP: begin
        ctrl.setup = 1'b1;
        state_nxt  = stat.color_ok ? ST_WALK : ST_DONE;
      end
      ST_WALK: begin
        ctrl.step = 1'b1;
        if (stat.walk_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        ctrl.load_zero = 1'b1;
        out_valid_nxt  = 1'b1;
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: design/ycc_chk.sv
// Port-level checker for the colour-class table, with its bind to the top level.
module ycc_chk
  import ycc_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic [CMD_W-1:0]  in_cmd,
  input logic              out_valid,
  input logic              out_ready,
  input logic [FLAG_W-1:0] out_color_flags,
  input logic [FLAG_W-1:0] out_color_mask
);

  logic [1:0] pend_r;
  cmd_code_t  last_cmd_r;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Items accepted whose result has not yet been taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r     <= '0;
      last_cmd_r <= CMD_CLASSIFY;
    end else begin
      pend_r <= pend_r + {1'b0, in_acc} - {1'b0, out_acc};
      if (in_acc) begin
        last_cmd_r <= in_cmd;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before it was taken");

  a_one_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r != 2'd2) && (!out_valid || (pend_r == 2'd1)))
    else $error("result without a matching item, or more than one item in flight");

  a_init_pass: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !in_ready)
    else $error("item accepted during the clearing pass");

  a_mask_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_color_mask == 8'h00) || (out_color_mask == 8'hFF))
    else $error("mask is neither 0 nor 255");

  a_train_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (last_cmd_r != CMD_CLASSIFY) |-> (out_color_flags == '0) && (out_color_mask == '0))
    else $error("training or clear item returned a non-zero result");

endmodule

bind ycrcb_color_class_lut ycc_chk u_ycc_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_chan.valid),
  .in_ready        (in_chan.ready),
  .in_cmd          (in_chan.cmd),
  .out_valid       (out_chan.valid),
  .out_ready       (out_chan.ready),
  .out_color_flags (out_chan.color_flags),
  .out_color_mask  (out_chan.color_mask)
);

// File: verif/ycc_class_checker.sv
// Checker for the colour-class table: keeps a shadow table, predicts every result and compares.
`timescale 1ns / 1ps

module ycc_class_checker
  import ycc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  ycc_in_if           in_mon,
  ycc_out_if          out_mon,
  output int unsigned fail_count,
  output int unsigned pending,
  output int unsigned mask_hits
);

  localparam logic [FLAG_W-1:0] MASK_ON = '1;

  typedef struct packed {
    logic [FLAG_W-1:0] flags;
    logic [FLAG_W-1:0] mask;
  } class_result_t;

  logic [FLAG_W-1:0] shadow_table [TABLE_DEPTH];
  class_result_t     expected_q [$];

  function automatic logic [ADDR_W-1:0] entry_addr(int y, int r, int b);
    return ADDR_W'((y << (2 * CHROMA_BITS)) | (r << CHROMA_BITS) | b);
  endfunction

  // Applies one command to the shadow table and returns the result it should give.
  function automatic class_result_t apply_command(
    cmd_code_t op, logic [PIX_W-1:0] luma, logic [PIX_W-1:0] red, logic [PIX_W-1:0] blue,
    logic [CIDX_W-1:0] colour, logic [YR_W-1:0] y_span, logic [CR_W-1:0] c_span);
    class_result_t     res;
    int                ys, rs, bs;
    int                y_lo, y_hi, r_lo, r_hi, b_lo, b_hi;
    logic [FLAG_W-1:0] bit_sel;
    logic              colour_ok;
    logic [ADDR_W-1:0] addr;
    res       = '0;
    ys        = int'(luma >> (PIX_W - LUMA_BITS));
    rs        = int'(red >> (PIX_W - CHROMA_BITS));
    bs        = int'(blue >> (PIX_W - CHROMA_BITS));
    bit_sel   = FLAG_W'(1) << colour;
    colour_ok = int'(colour) < NUM_COLORS;
    case (op)
      CMD_CLASSIFY: begin
        res.flags = shadow_table[entry_addr(ys, rs, bs)];
        if (colour_ok && (res.flags & bit_sel) != '0) res.mask = MASK_ON;
      end
      CMD_ADD, CMD_REMOVE: begin
        if (colour_ok) begin
          // The box is clipped to the table on every axis.
          y_lo = (ys - int'(y_span) < 0) ? 0 : ys - int'(y_span);
          y_hi = (ys + int'(y_span) > int'(Y_MAX)) ? int'(Y_MAX) : ys + int'(y_span);
          r_lo = (rs - int'(c_span) < 0) ? 0 : rs - int'(c_span);
          r_hi = (rs + int'(c_span) > int'(C_MAX)) ? int'(C_MAX) : rs + int'(c_span);
          b_lo = (bs - int'(c_span) < 0) ? 0 : bs - int'(c_span);
          b_hi = (bs + int'(c_span) > int'(C_MAX)) ? int'(C_MAX) : bs + int'(c_span);
          for (int y = y_lo; y <= y_hi; y++)
            for (int r = r_lo; r <= r_hi; r++)
              for (int b = b_lo; b <= b_hi; b++) begin
                addr = entry_addr(y, r, b);
                if (op == CMD_ADD) shadow_table[addr] = shadow_table[addr] | bit_sel;
                else shadow_table[addr] = shadow_table[addr] & ~bit_sel;
              end
        end
      end
      default: begin
        if (colour_ok)
          for (int i = 0; i < TABLE_DEPTH; i++) shadow_table[i] = shadow_table[i] & ~bit_sel;
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : watch
    class_result_t want;
    if (!rst_n) begin
      expected_q.delete();
      for (int i = 0; i < TABLE_DEPTH; i++) shadow_table[i] = '0;
      fail_count = 0;
      mask_hits  = 0;
    end else begin
      // Results are checked before new commands so that a stray result is never matched
      // against a command taken at the same edge.
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result, expected none, got flags %02h mask %02h",
                   $time, out_mon.color_flags, out_mon.color_mask);
        end else begin
          want = expected_q.pop_front();
          if (out_mon.color_flags !== want.flags) begin
            fail_count++;
            $display("%0t: color_flags mismatch, expected %02h, got %02h",
                     $time, want.flags, out_mon.color_flags);
          end
          if (out_mon.color_mask !== want.mask) begin
            fail_count++;
            $display("%0t: color_mask mismatch, expected %02h, got %02h",
                     $time, want.mask, out_mon.color_mask);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        want = apply_command(in_mon.cmd, in_mon.luma, in_mon.red_diff, in_mon.blue_diff,
                             in_mon.color_index, in_mon.luma_range, in_mon.chroma_range);
        if (want.mask != '0) mask_hits++;
        expected_q.insert(expected_q.size(), want);
      end
    end
    pending = expected_q.size();
  end

endmodule

// File: verif/testbench.sv
// Top of the colour-class table testbench: clock, reset, command stimulus, result sink, verdict.
`timescale 1ns / 1ps

module testbench;
  import ycc_pkg::*;

  localparam time         CLK_PERIOD        = 10ns;
  // The slowest correct run is dominated by the reset sweep, the whole-table commands
  // (two full boxes and up to four clears) and the wide random boxes; the limit leaves
  // ample room for all of them.
  localparam int unsigned CYCLE_LIMIT       = 4_000_000;
  localparam int unsigned RANDOM_ITEMS      = 880;
  localparam int unsigned MAX_RANDOM_CLEARS = 3;
  localparam int unsigned LONG_HOLD         = 300;
  localparam int unsigned BURST_ITEMS       = 16;
  localparam int unsigned TAIL_CYCLES       = 20;
  localparam int unsigned TRAINED_KEEP      = 32;

  // One command item as it travels on the input channel.
  typedef struct packed {
    cmd_code_t          cmd;
    logic [PIX_W-1:0]   luma;
    logic [PIX_W-1:0]   red_diff;
    logic [PIX_W-1:0]   blue_diff;
    logic [CIDX_W-1:0]  color_index;
    logic [YR_W-1:0]    luma_range;
    logic [CR_W-1:0]    chroma_range;
  } lut_command_t;

  logic        clk;
  logic        rst_n;
  int unsigned cycle_count = 0;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned mask_hits;

  // Pacing controls shared by the command and result sides.
  bit          tx_quiet    = 1'b0;
  bit          rx_quiet    = 1'b0;
  bit          hold_toggle = 1'b0;
  int unsigned clears_left = MAX_RANDOM_CLEARS;
  int unsigned op_count [4];

  // Pixels recently trained by random add commands; classify and remove aim near them.
  logic [3*PIX_W-1:0] trained_px [$];

  ycc_in_if  in_chan ();
  ycc_out_if out_chan ();

  ycrcb_color_class_lut uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  ycc_class_checker class_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .fail_count (fail_count),
    .pending    (pending),
    .mask_hits  (mask_hits)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // Watchdog: a hung handshake must still end the run with a verdict.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.", cycle_count, pending);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    if (r < 98) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic lut_command_t make_command(cmd_code_t op, logic [PIX_W-1:0] y,
                                                logic [PIX_W-1:0] cr, logic [PIX_W-1:0] cb,
                                                logic [CIDX_W-1:0] colour,
                                                logic [YR_W-1:0] y_span,
                                                logic [CR_W-1:0] c_span);
    lut_command_t c;
    c.cmd          = op;
    c.luma         = y;
    c.red_diff     = cr;
    c.blue_diff    = cb;
    c.color_index  = colour;
    c.luma_range   = y_span;
    c.chroma_range = c_span;
    return c;
  endfunction

  function automatic logic [PIX_W-1:0] jitter(logic [PIX_W-1:0] v, int spread);
    int t;
    t = int'(v) + int'($urandom_range(2 * spread)) - spread;
    if (t < 0) t = 0;
    if (t > 255) t = 255;
    return PIX_W'(t);
  endfunction

  // Moves a command's pixel to somewhere close to a pixel that was trained earlier, so that
  // classify and remove commands land on entries whose bits are actually set.
  function automatic lut_command_t aim_near_trained(lut_command_t c);
    logic [3*PIX_W-1:0] px;
    px          = trained_px[$urandom_range(trained_px.size() - 1)];
    c.luma      = jitter(px[3*PIX_W-1:2*PIX_W], 24);
    c.red_diff  = jitter(px[2*PIX_W-1:PIX_W], 10);
    c.blue_diff = jitter(px[PIX_W-1:0], 10);
    return c;
  endfunction

  // Random commands: about half classify, the rest mostly training boxes of modest size, a
  // handful of wide boxes and very few clears, since a clear walks the whole table.
  function automatic lut_command_t random_command();
    lut_command_t c;
    int unsigned  pick;
    int unsigned  shape;
    c = make_command(CMD_CLASSIFY, PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom),
                     CIDX_W'($urandom), YR_W'($urandom), CR_W'($urandom));
    pick = $urandom_range(99);
    if (pick < 50) begin
      if (trained_px.size() != 0 && $urandom_range(9) < 7) c = aim_near_trained(c);
      return c;
    end
    if (pick >= 97) begin
      if (clears_left != 0) begin
        clears_left--;
        c.cmd = CMD_CLEAR;
      end
      return c;
    end
    shape = $urandom_range(99);
    if (shape < 80) begin
      c.luma_range   = YR_W'($urandom_range(2));
      c.chroma_range = CR_W'($urandom_range(4));
    end else if (shape < 95) begin
      c.chroma_range = CR_W'($urandom_range(1));
    end else begin
      c.luma_range   = '0;
    end
    if (pick < 76) begin
      c.cmd = CMD_ADD;
      trained_px.insert(trained_px.size(), {c.luma, c.red_diff, c.blue_diff});
      if (trained_px.size() > TRAINED_KEEP) void'(trained_px.pop_front());
    end else begin
      c.cmd = CMD_REMOVE;
      if (trained_px.size() != 0 && $urandom_range(9) < 6) c = aim_near_trained(c);
    end
    return c;
  endfunction

  // Offers one item, waits for it to be taken, then idles for a random gap. The valid line is
  // only lowered when a gap follows, so back-to-back items keep it high.
  task automatic send_command(input lut_command_t c);
    int unsigned gap;
    in_chan.valid        <= 1'b1;
    in_chan.cmd          <= c.cmd;
    in_chan.luma         <= c.luma;
    in_chan.red_diff     <= c.red_diff;
    in_chan.blue_diff    <= c.blue_diff;
    in_chan.color_index  <= c.color_index;
    in_chan.luma_range   <= c.luma_range;
    in_chan.chroma_range <= c.chroma_range;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    op_count[c.cmd]++;
    gap = tx_quiet ? 0 : pick_gap();
    if (gap != 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering items until every result still owed has come back.
  task automatic drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
  endtask

  // Result side: random stalls, stretches of none, and a long hold-off on request.
  initial begin : result_sink
    bit          hold_seen;
    int unsigned stall;
    hold_seen = 1'b0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_toggle != hold_seen) begin
        hold_seen = hold_toggle;
        out_chan.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_chan.ready <= 1'b1;
      end else if (rx_quiet) begin
        out_chan.ready <= 1'b1;
      end else begin
        stall = pick_gap();
        if (stall == 0) begin
          out_chan.ready <= 1'b1;
        end else begin
          out_chan.ready <= 1'b0;
          repeat (stall - 1) @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    in_chan.valid        <= 1'b0;
    in_chan.cmd          <= CMD_CLASSIFY;
    in_chan.luma         <= '0;
    in_chan.red_diff     <= '0;
    in_chan.blue_diff    <= '0;
    in_chan.color_index  <= '0;
    in_chan.luma_range   <= '0;
    in_chan.chroma_range <= '0;
    rst_n                <= 1'b0;
    foreach (op_count[i]) op_count[i] = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. The first item also waits out the clearing pass after reset.
    // A freshly cleared table reads zero at both corners.
    send_command(make_command(CMD_CLASSIFY, 8'h00, 8'h00, 8'h00, 3'd0, 4'd0, 6'd0));
    send_command(make_command(CMD_CLASSIFY, 8'hFF, 8'hFF, 8'hFF, 3'd7, 4'hF, 6'h3F));
    // With both ranges zero the box is the single downsampled pixel: the same cell hits,
    // its luma neighbour misses, and another colour sees the flags but no mask.
    send_command(make_command(CMD_ADD, 8'd128, 8'd128, 8'd128, 3'd0, 4'd0, 6'd0));
    send_command(make_command(CMD_CLASSIFY, 8'd128, 8'd128, 8'd128, 3'd0, 4'd9, 6'd33));
    send_command(make_command(CMD_CLASSIFY, 8'd143, 8'd131, 8'd131, 3'd0, 4'd0, 6'd0));
    send_command(make_command(CMD_CLASSIFY, 8'd144, 8'd128, 8'd128, 3'd0, 4'd0, 6'd0));
    send_command(make_command(CMD_CLASSIFY, 8'd128, 8'd128, 8'd128, 3'd1, 4'd0, 6'd0));
    // Boxes that run off the low and the high edge of every axis are clipped, not dropped.
    send_command(make_command(CMD_ADD, 8'h00, 8'h00, 8'h00, 3'd1, 4'd3, 6'd5));
    send_command(make_command(CMD_ADD, 8'hFF, 8'hFF, 8'hFF, 3'd2, 4'd2, 6'd2));
    send_command(make_command(CMD_CLASSIFY, 8'h30, 8'h14, 8'h14, 3'd1, 4'd0, 6'd0));
    send_command(make_command(CMD_CLASSIFY, 8'hFF, 8'hFF, 8'hFF, 3'd2, 4'd0, 6'd0));
    send_command(make_command(CMD_CLASSIFY, 8'h40, 8'h18, 8'h00, 3'd1, 4'd0, 6'd0));
    // Widest ranges from a corner cover the whole table; then the whole table is removed.
    send_command(make_command(CMD_ADD, 8'hFF, 8'hFF, 8'hFF, 3'd7, 4'hF, 6'h3F));
    send_command(make_command(CMD_CLASSIFY, 8'h00, 8'h00, 8'h00, 3'd7, 4'd0, 6'd0));
    send_command(make_command(CMD_CLASSIFY, 8'd77, 8'd200, 8'd33, 3'd7, 4'd0, 6'd0));
    send_command(make_command(CMD_REMOVE, 8'd128, 8'd128, 8'd128, 3'd0, 4'd0, 6'd0));
    send_command(make_command(CMD_CLASSIFY, 8'd128, 8'd128, 8'd128, 3'd0, 4'd0, 6'd0));
    send_command(make_command(CMD_REMOVE, 8'h00, 8'h00, 8'h00, 3'd7, 4'hF, 6'h3F));
    send_command(make_command(CMD_CLASSIFY, 8'd77, 8'd200, 8'd33, 3'd7, 4'd0, 6'd0));
    send_command(make_command(CMD_ADD, 8'd100, 8'd60, 8'd200, 3'd5, 4'd1, 6'd1));
    // Clearing one colour leaves the others alone.
    send_command(make_command(CMD_CLEAR, 8'h5A, 8'hA5, 8'h3C, 3'd1, 4'd6, 6'd21));
    send_command(make_command(CMD_CLASSIFY, 8'h30, 8'h14, 8'h14, 3'd1, 4'd0, 6'd0));
    send_command(make_command(CMD_CLASSIFY, 8'hFF, 8'hFF, 8'hFF, 3'd2, 4'd0, 6'd0));
    send_command(make_command(CMD_CLASSIFY, 8'd100, 8'd60, 8'd200, 3'd5, 4'd0, 6'd0));

    // Back-pressure: the result side holds off for a long stretch while classify items keep
    // coming without gaps, so the output register fills and the input stalls.
    drain();
    hold_toggle = ~hold_toggle;
    tx_quiet    = 1'b1;
    for (int i = 0; i < BURST_ITEMS; i++)
      send_command(make_command(CMD_CLASSIFY, PIX_W'($urandom), 8'hFF, 8'hFF, 3'd2,
                                YR_W'($urandom), CR_W'($urandom)));
    tx_quiet = 1'b0;
    drain();

    // Random part, with a stretch free of idling on both sides, a pause until everything
    // owed has returned, and a second long hold-off further on.
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 300) begin
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
      end
      if (i == 420) begin
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
      end
      if (i == 500) drain();
      if (i == 650) hold_toggle = ~hold_toggle;
      send_command(random_command());
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d classify, %0d add, %0d remove, %0d clear items; %0d masks set.",
             op_count[CMD_CLASSIFY], op_count[CMD_ADD], op_count[CMD_REMOVE],
             op_count[CMD_CLEAR], mask_hits);
    $display("Run took %0d cycles with %0d check failures.", cycle_count, fail_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/ycc_pkg.sv
design/ycc_if.sv
design/ycc_dpath.sv
design/ycc_ctrl.sv
design/ycrcb_color_class_lut.sv
design/ycc_chk.sv
verif/ycc_class_checker.sv
verif/testbench.sv
